@@ rtl/core/pbrs_pkg.sv @@
// shared constants, types and helpers of the pupil box ray sampler
// no dependencies; imported by the top level

package pbrs_pkg;

  localparam int ZoneW     = 6;
  localparam int MaxZones  = 1 << ZoneW;
  localparam int CountW    = 7;
  localparam int CoordW    = 32;
  localparam int RadW      = 31;
  localparam int RandW     = 16;
  localparam int FracBits  = 16;
  localparam int AreaW     = 48;
  localparam int CfgW      = 31;
  localparam int CfgIdxW   = 2;

  // square root of a 64 bit sum, one result bit per stage
  localparam int RootW     = CoordW;
  localparam int SumW      = 2 * CoordW;
  localparam int RootSteps = RootW;

  // zone pick divider: quotient below MaxZones
  localparam int IxW       = RadW + ZoneW;

  // rotation divider: quotient magnitude below 2^33
  localparam int DivSteps  = CoordW + 1;
  localparam int NumW      = 2 * CoordW;
  localparam int ValW      = DivSteps + 2;

  localparam int Latency   = 3 + (RootSteps + 1) + (ZoneW + 1) + 6 + (DivSteps + 1) + 1;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic [AreaW-1:0]         AreaMax  = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZONE_COUNT  = 2'd0,
    CFG_FILM_RADIUS = 2'd1,
    CFG_REAR_SEMI   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_LENS = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] y1;
  } box_t;

  typedef struct packed {
    logic                     func;
    logic [ZoneW-1:0]         zidx;
    box_t                     box;
    logic signed [CoordW-1:0] fx;
    logic signed [CoordW-1:0] fy;
    logic [RandW-1:0]         u;
    logic [RandW-1:0]         v;
  } front_t;

  typedef struct packed {
    logic signed [CoordW-1:0] fx;
    logic signed [CoordW-1:0] fy;
    logic [RandW-1:0]         u;
    logic [RandW-1:0]         v;
    logic [RootW-1:0]         r;
  } geo_t;

  typedef struct packed {
    status_e                  status;
    logic                     r_zero;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic [AreaW-1:0]         area;
  } tail_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [ValW-1:0] v);
    if (v > ValW'(CoordMax)) begin
      return CoordMax;
    end else if (v < ValW'(CoordMin)) begin
      return CoordMin;
    end else begin
      return CoordW'(v);
    end
  endfunction

endpackage

@@ rtl/core/pbrs_ram.sv @@
// generic simple dual read ram, one write port, two registered read ports
// no dependencies

module pbrs_ram #(
  parameter int Width = 128,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/core/pupil_box_ray_sampler.sv @@
// top level of the pupil box ray sampler: full pipeline and zone table
// depends on pbrs_pkg and pbrs_ram

// A fully pipelined exit-pupil sampler. One item is taken on every clock
// (busy is never raised) and sample items give their results on done_o
// at a steady rate of one result per clock; the depth comes from the
// 32-step square root of the sensor radius, the 6-step zone pick divider
// and the 33-step divider that normalises the rotation.
// Results are shown for one cycle only and cannot be held off, so the
// receiver must take done_o as it comes. Write items give no result: each
// lands in the zone table when it reaches the table stage, the same place
// where samples read it, so items keep their order.
// The table has no reset; reading a zone never written gives undefined boxes.
// Configuration is to be written only while the pipeline is empty.

module pupil_box_ray_sampler
  import pbrs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     func_i,
  input  logic [ZoneW-1:0]         zone_index_i,
  input  logic signed [CoordW-1:0] box_x0_i,
  input  logic signed [CoordW-1:0] box_x1_i,
  input  logic signed [CoordW-1:0] box_y0_i,
  input  logic signed [CoordW-1:0] box_y1_i,
  input  logic signed [CoordW-1:0] film_x_i,
  input  logic signed [CoordW-1:0] film_y_i,
  input  logic [RandW-1:0]         rand_u_i,
  input  logic [RandW-1:0]         rand_v_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgW-1:0]          cfg_data_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [CoordW-1:0] point_x_o,
  output logic signed [CoordW-1:0] point_y_o,
  output logic [AreaW-1:0]         area_o
);

  // ---------------------------------------------------------------- config
  logic [CountW-1:0] zone_count_q;
  logic [RadW-1:0]   film_radius_q;
  logic [RadW-1:0]   rear_semi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_count_q  <= '0;
      film_radius_q <= '0;
      rear_semi_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ZONE_COUNT:  zone_count_q  <= cfg_data_i[CountW-1:0];
        CFG_FILM_RADIUS: film_radius_q <= cfg_data_i[RadW-1:0];
        CFG_REAR_SEMI:   rear_semi_q   <= cfg_data_i[RadW-1:0];
        default: ;
      endcase
    end
  end

  // effective zone count: clipped to the table, a single zone acts as two
  logic [CountW-1:0] n_sat;
  logic [CountW-1:0] n_eff;
  logic [ZoneW-1:0]  n_m1;
  logic [ZoneW-1:0]  n_m2;
  logic              has_table;
  logic              no_lens;

  always_comb begin
    n_sat     = (zone_count_q > CountW'(MaxZones)) ? CountW'(MaxZones) : zone_count_q;
    n_eff     = (n_sat == CountW'(1)) ? CountW'(2) : n_sat;
    n_m1      = ZoneW'(n_eff - CountW'(1));
    n_m2      = ZoneW'(n_eff - CountW'(2));
    has_table = (n_eff != '0);
    no_lens   = !has_table && (rear_semi_q == '0);
  end

  // nothing ever stalls the pipeline
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage registers
  logic   in_vld_q;
  front_t in_ctx_q;

  logic              ab_vld_q;
  front_t            ab_ctx_q;
  logic [CoordW-1:0] ab_x_q;
  logic [CoordW-1:0] ab_y_q;

  logic            sq_vld_q;
  front_t          sq_ctx_q;
  logic [SumW-1:0] sq_x_q;
  logic [SumW-1:0] sq_y_q;

  // square root chain, index 0 holds the sum of squares
  logic [RootSteps:0] rt_vld_q;
  front_t             rt_ctx_q  [RootSteps+1];
  logic [SumW-1:0]    rt_rem_q  [RootSteps+1];
  logic [RootW-1:0]   rt_root_q [RootSteps+1];
  logic [SumW-1:0]    rt_trial  [RootSteps];

  // zone pick divider, index 0 holds the clipped radius times (n-1)
  logic [ZoneW:0]     ix_vld_q;
  front_t             ix_ctx_q [ZoneW+1];
  logic [RootW-1:0]   ix_r_q   [ZoneW+1];
  logic [IxW-1:0]     ix_rem_q [ZoneW+1];
  logic [ZoneW-1:0]   ix_quo_q [ZoneW+1];
  logic [IxW-1:0]     ix_trial [ZoneW];
  logic [RadW-1:0]    rc;

  // table stage
  logic             rd_vld_q;
  geo_t             rd_geo_q;
  logic [ZoneW-1:0] idx_sel;
  front_t           ix_last;
  box_t             ram_a;
  box_t             ram_b;
  logic [4*CoordW-1:0] ram_rdata_a;
  logic [4*CoordW-1:0] ram_rdata_b;

  // union stage
  logic                     un_vld_q;
  geo_t                     un_geo_q;
  logic signed [CoordW-1:0] un_x0_q;
  logic signed [CoordW-1:0] un_y0_q;
  logic [CoordW-1:0]        un_w_q;
  logic [CoordW-1:0]        un_h_q;
  logic                     un_empty_q;
  logic signed [CoordW-1:0] ux0, ux1, uy0, uy1, semi_s;
  logic signed [CoordW:0]   uw, uh;

  // scaling products
  logic                      ml_vld_q;
  geo_t                      ml_geo_q;
  logic signed [CoordW-1:0]  ml_x0_q;
  logic signed [CoordW-1:0]  ml_y0_q;
  logic                      ml_empty_q;
  logic [CoordW+RandW-1:0]   ml_wu_q;
  logic [CoordW+RandW-1:0]   ml_hv_q;
  logic [2*CoordW-1:0]       ml_wh_q;

  // point and area
  logic                     pt_vld_q;
  tail_t                    pt_tail_q;
  geo_t                     pt_geo_q;
  logic [2*CoordW-1:0]      wh_sh;

  // rotation products and sums
  logic                     rm_vld_q;
  tail_t                    rm_tail_q;
  logic [RootW-1:0]         rm_r_q;
  logic signed [NumW-1:0]   rm_xx_q, rm_yy_q, rm_xy_q, rm_yx_q;

  logic                     rs_vld_q;
  tail_t                    rs_tail_q;
  logic [RootW-1:0]         rs_r_q;
  logic signed [NumW-1:0]   rs_nx_q, rs_ny_q;

  // rotation divider, index 0 holds the magnitudes
  logic [DivSteps:0]     dv_vld_q;
  tail_t                 dv_tail_q [DivSteps+1];
  logic [RootW-1:0]      dv_r_q    [DivSteps+1];
  logic [DivSteps:0]     dv_negx_q;
  logic [DivSteps:0]     dv_negy_q;
  logic [NumW-1:0]       dv_remx_q [DivSteps+1];
  logic [NumW-1:0]       dv_remy_q [DivSteps+1];
  logic [DivSteps-1:0]   dv_qx_q   [DivSteps+1];
  logic [DivSteps-1:0]   dv_qy_q   [DivSteps+1];
  logic [NumW-1:0]       dv_trial  [DivSteps];

  // output
  logic                     done_q;
  status_e                  out_status_q;
  logic signed [CoordW-1:0] out_x_q;
  logic signed [CoordW-1:0] out_y_q;
  logic [AreaW-1:0]         out_area_q;
  logic signed [ValW-1:0]   qx_ext, qy_ext, vx, vy;
  tail_t                    dv_last;

  // ---------------------------------------------------------------- combinational steps
  // root step: trial = (root << (j+1)) | (1 << 2j) for result bit j
  always_comb begin
    for (int k = 0; k < RootSteps; k++) begin
      rt_trial[k] = (SumW'(rt_root_q[k]) << (RootSteps - k))
                  | (SumW'(1) << (2 * (RootSteps - 1 - k)));
    end
  end

  always_comb begin
    rc = (rt_root_q[RootSteps] < RootW'(film_radius_q)) ? RadW'(rt_root_q[RootSteps])
                                                        : film_radius_q;
    for (int k = 0; k < ZoneW; k++) begin
      ix_trial[k] = IxW'(film_radius_q) << (ZoneW - 1 - k);
    end
  end

  // zone pick with cap at n-2; a zero film radius always picks zone 0
  always_comb begin
    ix_last = ix_ctx_q[ZoneW];
    if (film_radius_q == '0) begin
      idx_sel = '0;
    end else if (ix_quo_q[ZoneW] > n_m2) begin
      idx_sel = n_m2;
    end else begin
      idx_sel = ix_quo_q[ZoneW];
    end
  end

  pbrs_ram #(
    .Width (4 * CoordW),
    .Depth (MaxZones)
  ) u_zone_table (
    .clk_i     (clk_i),
    .we_i      (ix_vld_q[ZoneW] && ix_last.func),
    .waddr_i   (ix_last.zidx),
    .wdata_i   (ix_last.box),
    .raddr_a_i (idx_sel),
    .raddr_b_i (idx_sel + ZoneW'(1)),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  assign ram_a = ram_rdata_a;
  assign ram_b = ram_rdata_b;

  // union of the two bracketing boxes, or the rear element square
  always_comb begin
    semi_s = $signed({1'b0, rear_semi_q});
    if (has_table) begin
      ux0 = ($signed(ram_a.x0) < $signed(ram_b.x0)) ? ram_a.x0 : ram_b.x0;
      ux1 = ($signed(ram_a.x1) > $signed(ram_b.x1)) ? ram_a.x1 : ram_b.x1;
      uy0 = ($signed(ram_a.y0) < $signed(ram_b.y0)) ? ram_a.y0 : ram_b.y0;
      uy1 = ($signed(ram_a.y1) > $signed(ram_b.y1)) ? ram_a.y1 : ram_b.y1;
    end else begin
      ux0 = -semi_s;
      ux1 = semi_s;
      uy0 = -semi_s;
      uy1 = semi_s;
    end
    uw = $signed({ux1[CoordW-1], ux1}) - $signed({ux0[CoordW-1], ux0});
    uh = $signed({uy1[CoordW-1], uy1}) - $signed({uy0[CoordW-1], uy0});
  end

  assign wh_sh = ml_wh_q >> FracBits;

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      dv_trial[k] = NumW'(dv_r_q[k]) << (DivSteps - 1 - k);
    end
  end

  // floor of the signed quotient from magnitude quotient and remainder
  always_comb begin
    dv_last = dv_tail_q[DivSteps];
    qx_ext  = $signed({2'b00, dv_qx_q[DivSteps]});
    qy_ext  = $signed({2'b00, dv_qy_q[DivSteps]});
    vx = dv_negx_q[DivSteps] ? (-qx_ext - ValW'(|dv_remx_q[DivSteps])) : qx_ext;
    vy = dv_negy_q[DivSteps] ? (-qy_ext - ValW'(|dv_remy_q[DivSteps])) : qy_ext;
  end

  // ---------------------------------------------------------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      ab_vld_q <= 1'b0;
      sq_vld_q <= 1'b0;
      rt_vld_q <= '0;
      ix_vld_q <= '0;
      rd_vld_q <= 1'b0;
      un_vld_q <= 1'b0;
      ml_vld_q <= 1'b0;
      pt_vld_q <= 1'b0;
      rm_vld_q <= 1'b0;
      rs_vld_q <= 1'b0;
      dv_vld_q <= '0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= accept;
      ab_vld_q <= in_vld_q;
      sq_vld_q <= ab_vld_q;
      rt_vld_q <= {rt_vld_q[RootSteps-1:0], sq_vld_q};
      ix_vld_q <= {ix_vld_q[ZoneW-1:0], rt_vld_q[RootSteps]};
      // write items end at the table
      rd_vld_q <= ix_vld_q[ZoneW] && !ix_last.func;
      un_vld_q <= rd_vld_q;
      ml_vld_q <= un_vld_q;
      pt_vld_q <= ml_vld_q;
      rm_vld_q <= pt_vld_q;
      rs_vld_q <= rm_vld_q;
      dv_vld_q <= {dv_vld_q[DivSteps-1:0], rs_vld_q};
      done_q   <= dv_vld_q[DivSteps];
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_ctx_q <= '{func: func_i, zidx: zone_index_i,
                    box: '{x0: box_x0_i, x1: box_x1_i, y0: box_y0_i, y1: box_y1_i},
                    fx: film_x_i, fy: film_y_i, u: rand_u_i, v: rand_v_i};
    end

    // magnitudes and squares of the sensor point
    ab_ctx_q <= in_ctx_q;
    ab_x_q   <= in_ctx_q.fx[CoordW-1] ? CoordW'(-in_ctx_q.fx) : CoordW'(in_ctx_q.fx);
    ab_y_q   <= in_ctx_q.fy[CoordW-1] ? CoordW'(-in_ctx_q.fy) : CoordW'(in_ctx_q.fy);

    sq_ctx_q <= ab_ctx_q;
    sq_x_q   <= ab_x_q * ab_x_q;
    sq_y_q   <= ab_y_q * ab_y_q;

    rt_ctx_q[0]  <= sq_ctx_q;
    rt_rem_q[0]  <= sq_x_q + sq_y_q;
    rt_root_q[0] <= '0;
    for (int k = 0; k < RootSteps; k++) begin
      rt_ctx_q[k+1] <= rt_ctx_q[k];
      if (rt_rem_q[k] >= rt_trial[k]) begin
        rt_rem_q[k+1]  <= rt_rem_q[k] - rt_trial[k];
        rt_root_q[k+1] <= rt_root_q[k] | (RootW'(1) << (RootSteps - 1 - k));
      end else begin
        rt_rem_q[k+1]  <= rt_rem_q[k];
        rt_root_q[k+1] <= rt_root_q[k];
      end
    end

    ix_ctx_q[0] <= rt_ctx_q[RootSteps];
    ix_r_q[0]   <= rt_root_q[RootSteps];
    ix_rem_q[0] <= IxW'(rc) * IxW'(n_m1);
    ix_quo_q[0] <= '0;
    for (int k = 0; k < ZoneW; k++) begin
      ix_ctx_q[k+1] <= ix_ctx_q[k];
      ix_r_q[k+1]   <= ix_r_q[k];
      if (ix_rem_q[k] >= ix_trial[k]) begin
        ix_rem_q[k+1] <= ix_rem_q[k] - ix_trial[k];
        ix_quo_q[k+1] <= ix_quo_q[k] | (ZoneW'(1) << (ZoneW - 1 - k));
      end else begin
        ix_rem_q[k+1] <= ix_rem_q[k];
        ix_quo_q[k+1] <= ix_quo_q[k];
      end
    end

    // table read is issued here, data arrives with the next stage
    rd_geo_q <= '{fx: ix_last.fx, fy: ix_last.fy, u: ix_last.u, v: ix_last.v,
                  r: ix_r_q[ZoneW]};

    un_geo_q   <= rd_geo_q;
    un_x0_q    <= ux0;
    un_y0_q    <= uy0;
    un_w_q     <= uw[CoordW-1:0];
    un_h_q     <= uh[CoordW-1:0];
    un_empty_q <= uw[CoordW] || (uw == '0) || uh[CoordW] || (uh == '0);

    ml_geo_q   <= un_geo_q;
    ml_x0_q    <= un_x0_q;
    ml_y0_q    <= un_y0_q;
    ml_empty_q <= un_empty_q;
    ml_wu_q    <= un_w_q * un_geo_q.u;
    ml_hv_q    <= un_h_q * un_geo_q.v;
    ml_wh_q    <= un_w_q * un_h_q;

    pt_geo_q         <= ml_geo_q;
    pt_tail_q.status <= no_lens ? ST_NO_LENS : (ml_empty_q ? ST_EMPTY : ST_OK);
    pt_tail_q.r_zero <= (ml_geo_q.r == '0);
    pt_tail_q.px     <= ml_x0_q + $signed(CoordW'(ml_wu_q >> RandW));
    pt_tail_q.py     <= ml_y0_q + $signed(CoordW'(ml_hv_q >> RandW));
    pt_tail_q.area   <= (wh_sh > (2*CoordW)'(AreaMax)) ? AreaMax : AreaW'(wh_sh);

    rm_tail_q <= pt_tail_q;
    rm_r_q    <= pt_geo_q.r;
    rm_xx_q   <= pt_tail_q.px * pt_geo_q.fx;
    rm_yy_q   <= pt_tail_q.py * pt_geo_q.fy;
    rm_xy_q   <= pt_tail_q.px * pt_geo_q.fy;
    rm_yx_q   <= pt_tail_q.py * pt_geo_q.fx;

    rs_tail_q <= rm_tail_q;
    rs_r_q    <= rm_r_q;
    rs_nx_q   <= rm_xx_q - rm_yy_q;
    rs_ny_q   <= rm_xy_q + rm_yx_q;

    dv_tail_q[0] <= rs_tail_q;
    dv_r_q[0]    <= rs_r_q;
    dv_negx_q[0] <= rs_nx_q[NumW-1];
    dv_negy_q[0] <= rs_ny_q[NumW-1];
    dv_remx_q[0] <= rs_nx_q[NumW-1] ? NumW'(-rs_nx_q) : NumW'(rs_nx_q);
    dv_remy_q[0] <= rs_ny_q[NumW-1] ? NumW'(-rs_ny_q) : NumW'(rs_ny_q);
    dv_qx_q[0]   <= '0;
    dv_qy_q[0]   <= '0;
    for (int k = 0; k < DivSteps; k++) begin
      dv_tail_q[k+1] <= dv_tail_q[k];
      dv_r_q[k+1]    <= dv_r_q[k];
      dv_negx_q[k+1] <= dv_negx_q[k];
      dv_negy_q[k+1] <= dv_negy_q[k];
      if (dv_remx_q[k] >= dv_trial[k]) begin
        dv_remx_q[k+1] <= dv_remx_q[k] - dv_trial[k];
        dv_qx_q[k+1]   <= dv_qx_q[k] | (DivSteps'(1) << (DivSteps - 1 - k));
      end else begin
        dv_remx_q[k+1] <= dv_remx_q[k];
        dv_qx_q[k+1]   <= dv_qx_q[k];
      end
      if (dv_remy_q[k] >= dv_trial[k]) begin
        dv_remy_q[k+1] <= dv_remy_q[k] - dv_trial[k];
        dv_qy_q[k+1]   <= dv_qy_q[k] | (DivSteps'(1) << (DivSteps - 1 - k));
      end else begin
        dv_remy_q[k+1] <= dv_remy_q[k];
        dv_qy_q[k+1]   <= dv_qy_q[k];
      end
    end

    // no lens and empty box give zeros; a point at the origin is not rotated
    out_status_q <= dv_last.status;
    if (dv_last.status != ST_OK) begin
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_area_q <= '0;
    end else begin
      out_x_q    <= dv_last.r_zero ? dv_last.px : sat_coord(vx);
      out_y_q    <= dv_last.r_zero ? dv_last.py : sat_coord(vy);
      out_area_q <= dv_last.area;
    end
  end

  assign done_o    = done_q;
  assign status_o  = out_status_q;
  assign point_x_o = out_x_q;
  assign point_y_o = out_y_q;
  assign area_o    = out_area_q;

  // ---------------------------------------------------------------- assertions
  // every result traces back to a sample item taken exactly one latency ago
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && !func_i, Latency))
    else $error("result without a matching sample item");

  // failed samples carry no point and no area
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (point_x_o == '0 && point_y_o == '0 && area_o == '0))
    else $error("failed sample with non-zero payload");

  // zone divider ends with a proper remainder and a zone pair inside the table
  a_zone_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ix_vld_q[ZoneW] && !ix_last.func && has_table && film_radius_q != '0) |->
      (ix_rem_q[ZoneW] < IxW'(film_radius_q) && idx_sel <= n_m2))
    else $error("zone pick out of range");

  // rotation divider never overflows its quotient
  a_rot_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_vld_q[DivSteps] && !dv_last.r_zero) |->
      (dv_remx_q[DivSteps] < NumW'(dv_r_q[DivSteps]) &&
       dv_remy_q[DivSteps] < NumW'(dv_r_q[DivSteps])))
    else $error("rotation divider remainder not below radius");

endmodule
